// File: src/softmax_tanh_activation_core_assert.svh
// Assertion macros shared by the activation core.
`ifndef SOFTMAX_TANH_ACTIVATION_CORE_ASSERT_SVH
`define SOFTMAX_TANH_ACTIVATION_CORE_ASSERT_SVH

// Checked only outside reset.
`define STA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define STA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: src/sta_pkg.sv
package sta_pkg;

  // Q8.8 input element and Q1.15 result share this shape
  typedef logic signed [15:0] elem_t;

  // Q16 fraction, 65536 = 1.0
  typedef logic [16:0] q16_t;

  localparam logic [15:0] SAT_MAX = 16'h7FFF;

  // exp(-i), i integer part; zero from 12 up
  function automatic q16_t exp_int_f(input logic [3:0] i);
    q16_t r;
    case (i)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd24109;
      4'd2:    r = 17'd8869;
      4'd3:    r = 17'd3263;
      4'd4:    r = 17'd1200;
      4'd5:    r = 17'd442;
      4'd6:    r = 17'd162;
      4'd7:    r = 17'd60;
      4'd8:    r = 17'd22;
      4'd9:    r = 17'd8;
      4'd10:   r = 17'd3;
      4'd11:   r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // exp(-h/16)
  function automatic q16_t exp_hi_f(input logic [3:0] h);
    q16_t r;
    case (h)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd61565;
      4'd2:    r = 17'd57835;
      4'd3:    r = 17'd54331;
      4'd4:    r = 17'd51039;
      4'd5:    r = 17'd47947;
      4'd6:    r = 17'd45042;
      4'd7:    r = 17'd42313;
      4'd8:    r = 17'd39750;
      4'd9:    r = 17'd37341;
      4'd10:   r = 17'd35079;
      4'd11:   r = 17'd32954;
      4'd12:   r = 17'd30957;
      4'd13:   r = 17'd29081;
      4'd14:   r = 17'd27319;
      default: r = 17'd25664;
    endcase
    return r;
  endfunction

  // exp(-l/256)
  function automatic q16_t exp_lo_f(input logic [3:0] l);
    q16_t r;
    case (l)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd65280;
      4'd2:    r = 17'd65026;
      4'd3:    r = 17'd64772;
      4'd4:    r = 17'd64520;
      4'd5:    r = 17'd64268;
      4'd6:    r = 17'd64018;
      4'd7:    r = 17'd63768;
      4'd8:    r = 17'd63520;
      4'd9:    r = 17'd63272;
      4'd10:   r = 17'd63025;
      4'd11:   r = 17'd62780;
      4'd12:   r = 17'd62535;
      4'd13:   r = 17'd62291;
      4'd14:   r = 17'd62048;
      default: r = 17'd61806;
    endcase
    return r;
  endfunction

endpackage

// File: src/sta_if.sv
interface sta_in_if;
  logic            valid;
  logic            ready;
  sta_pkg::elem_t  element_value;
  logic            element_last;

  modport source (output valid, element_value, element_last, input ready);
  modport sink (input valid, element_value, element_last, output ready);
endinterface

interface sta_out_if;
  logic            valid;
  logic            ready;
  sta_pkg::elem_t  result_value;
  logic            result_last;
  logic            overflow_flag;

  modport source (output valid, result_value, result_last, overflow_flag, input ready);
  modport sink (input valid, result_value, result_last, overflow_flag, output ready);
endinterface

// File: src/sta_ram.sv
module sta_ram #(
  parameter int Width = 16,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: src/softmax_tanh_activation_core.sv
// Vector activation core. With the mode bit at 0 (softmax) each word is
// stored as it arrives, one per cycle, until the word flagged last; then the
// core walks the stored vector twice: once to sum exp(x - max), once to emit
// exp(x - max) / sum in Q0.15 for every element in arrival order. Words past
// VEC_LEN are dropped and every result of that vector carries overflow_flag.
// With the mode bit at 1 (tanh) each word yields one Q1.15 result. The core
// takes no new word while it works. All arithmetic runs through one 17x17
// multiplier (two products per exponential, none where an exponential
// underflows to zero) and a one-bit-per-cycle divider. A finished result
// waits in the output register while the core goes on. The element store
// needs no clearing after reset. Writing the mode bit discards a partly
// gathered vector; write it only while the core is idle.
`include "softmax_tanh_activation_core_assert.svh"

module softmax_tanh_activation_core #(
  parameter int VEC_LEN = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  sta_in_if.sink           elem_i,
  sta_out_if.source        res_o
);

  localparam int CNT_W  = $clog2(VEC_LEN + 1);
  localparam int ADDR_W = $clog2(VEC_LEN);

  localparam int          ST_W    = 4;
  localparam logic [3:0]  ST_IDLE = 4'd0;
  localparam logic [3:0]  ST_RD   = 4'd1;
  localparam logic [3:0]  ST_LOAD = 4'd2;
  localparam logic [3:0]  ST_MUL1 = 4'd3;
  localparam logic [3:0]  ST_RND1 = 4'd4;
  localparam logic [3:0]  ST_MUL2 = 4'd5;
  localparam logic [3:0]  ST_RND2 = 4'd6;
  localparam logic [3:0]  ST_POST = 4'd7;
  localparam logic [3:0]  ST_DIV  = 4'd8;
  localparam logic [3:0]  ST_EMIT = 4'd9;

  localparam logic MODE_SOFTMAX = 1'b0;

  // control state
  logic [ST_W-1:0]  state_q, state_d;
  logic             kind_q, kind_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  sta_pkg::elem_t   max_q, max_d;
  logic [23:0]      sum_q, sum_d;
  logic             drop_q, drop_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic             pass_q, pass_d;
  logic [3:0]       bit_q, bit_d;
  logic             out_valid_q, out_valid_d;

  // datapath
  logic [15:0]      dist_q, dist_d;
  logic [33:0]      prod_q, prod_d;
  sta_pkg::q16_t    p_q, p_d;
  sta_pkg::q16_t    e_q, e_d;
  logic [23:0]      rem_q, rem_d;
  logic [15:0]      num_q, num_d;
  logic [23:0]      div_q, div_d;
  logic             neg_q, neg_d;
  logic             last_q, last_d;
  sta_pkg::elem_t   out_value_q, out_value_d;
  logic             out_last_q, out_last_d;
  logic             out_ovf_q, out_ovf_d;

  logic              in_fire;
  logic              ram_we;
  sta_pkg::elem_t    ram_rdata;
  sta_pkg::q16_t     mul_a, mul_b;
  logic [33:0]       mul_p;
  logic [33:0]       rnd_sum;
  sta_pkg::q16_t     rnd_val;
  logic [16:0]       x_ext, mag;
  logic [17:0]       twice;
  logic [16:0]       diff;
  logic [17:0]       tanh_den;
  logic [31:0]       num_full;
  logic [23:0]       den_full;
  logic [24:0]       trial;
  logic              trial_ge;
  logic [24:0]       trial_sub;
  logic [15:0]       sat_val;
  logic              emit_go;
  logic              emit_last;

  assign in_fire      = elem_i.valid && elem_i.ready;
  assign elem_i.ready = (state_q == ST_IDLE);

  assign res_o.valid         = out_valid_q;
  assign res_o.result_value  = out_value_q;
  assign res_o.result_last   = out_last_q;
  assign res_o.overflow_flag = out_ovf_q;

  assign ram_we = in_fire && (kind_q == MODE_SOFTMAX) && (cnt_q < CNT_W'(VEC_LEN));

  sta_ram #(
    .Width (16),
    .Depth (VEC_LEN)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[ADDR_W-1:0]),
    .wdata_i (elem_i.element_value),
    .raddr_i (k_q[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // shared multiplier: integer x high-fraction term, then x low-fraction term
  assign mul_a   = (state_q == ST_MUL1) ? sta_pkg::exp_int_f(dist_q[11:8]) : p_q;
  assign mul_b   = (state_q == ST_MUL1) ? sta_pkg::exp_hi_f(dist_q[7:4])
                                        : sta_pkg::exp_lo_f(dist_q[3:0]);
  assign mul_p   = 34'(mul_a) * 34'(mul_b);
  assign rnd_sum = prod_q + 34'd32768;
  assign rnd_val = rnd_sum[32:16];

  // tanh distance: 2|x| clamped to 16 bits
  assign x_ext = {elem_i.element_value[15], elem_i.element_value};
  assign mag   = elem_i.element_value[15] ? (17'd0 - x_ext) : x_ext;
  assign twice = {mag, 1'b0};

  // softmax distance max - x, never negative
  assign diff = {max_q[15], max_q} - {ram_rdata[15], ram_rdata};

  // divider operands
  assign tanh_den = 18'd65536 + 18'(e_q);
  always_comb begin
    if (kind_q != MODE_SOFTMAX) begin
      num_full = {(17'd65536 - e_q), 15'd0} + 32'(tanh_den[17:1]);
      den_full = 24'(tanh_den);
    end else begin
      num_full = {e_q, 15'd0} + 32'(sum_q[23:1]);
      den_full = sum_q;
    end
  end

  assign trial     = {rem_q, num_q[15]};
  assign trial_ge  = (trial >= {1'b0, div_q});
  assign trial_sub = trial - {1'b0, div_q};

  assign sat_val   = num_q[15] ? sta_pkg::SAT_MAX : num_q;
  assign emit_go   = (state_q == ST_EMIT) && (!out_valid_q || res_o.ready);
  assign emit_last = ((k_q + CNT_W'(1)) == cnt_q);

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    cnt_d       = cnt_q;
    max_d       = max_q;
    sum_d       = sum_q;
    drop_d      = drop_q;
    k_d         = k_q;
    pass_d      = pass_q;
    bit_d       = bit_q;
    out_valid_d = out_valid_q;
    dist_d      = dist_q;
    prod_d      = prod_q;
    p_d         = p_q;
    e_d         = e_q;
    rem_d       = rem_q;
    num_d       = num_q;
    div_d       = div_q;
    neg_d       = neg_q;
    last_d      = last_q;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;

    if (res_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (kind_q != MODE_SOFTMAX) begin
            neg_d   = elem_i.element_value[15];
            last_d  = elem_i.element_last;
            dist_d  = (twice[17:16] != 2'd0) ? 16'hFFFF : twice[15:0];
            state_d = ST_MUL1;
          end else begin
            if (cnt_q < CNT_W'(VEC_LEN)) begin
              cnt_d = cnt_q + CNT_W'(1);
              if (elem_i.element_value > max_q) begin
                max_d = elem_i.element_value;
              end
            end else begin
              drop_d = 1'b1;
            end
            if (elem_i.element_last) begin
              k_d     = '0;
              pass_d  = 1'b0;
              sum_d   = '0;
              state_d = ST_RD;
            end
          end
        end
      end
      ST_RD: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        dist_d  = diff[15:0];
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        // from a distance of 12 up the table gives zero
        if (dist_q[15:8] >= 8'd12) begin
          e_d     = '0;
          state_d = ST_POST;
        end else begin
          prod_d  = mul_p;
          state_d = ST_RND1;
        end
      end
      ST_RND1: begin
        p_d     = rnd_val;
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        prod_d  = mul_p;
        state_d = ST_RND2;
      end
      ST_RND2: begin
        e_d     = rnd_val;
        state_d = ST_POST;
      end
      ST_POST: begin
        if ((kind_q == MODE_SOFTMAX) && !pass_q) begin
          sum_d = sum_q + 24'(e_q);
          if (emit_last) begin
            k_d    = '0;
            pass_d = 1'b1;
          end else begin
            k_d = k_q + CNT_W'(1);
          end
          state_d = ST_RD;
        end else if (den_full == 24'd0) begin
          num_d   = '0;
          state_d = ST_EMIT;
        end else begin
          rem_d   = 24'(num_full[31:16]);
          num_d   = num_full[15:0];
          div_d   = den_full;
          bit_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        // restoring divide, quotient bits shift in behind the numerator
        rem_d = trial_ge ? trial_sub[23:0] : trial[23:0];
        num_d = {num_q[14:0], trial_ge};
        bit_d = bit_q + 4'd1;
        if (bit_q == 4'd15) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_valid_d = 1'b1;
          if (kind_q != MODE_SOFTMAX) begin
            out_value_d = neg_q ? (16'sd0 - sta_pkg::elem_t'(sat_val))
                                : sta_pkg::elem_t'(sat_val);
            out_last_d  = last_q;
            out_ovf_d   = 1'b0;
            state_d     = ST_IDLE;
          end else begin
            out_value_d = sta_pkg::elem_t'(sat_val);
            out_last_d  = emit_last;
            out_ovf_d   = drop_q;
            if (emit_last) begin
              cnt_d   = '0;
              max_d   = 16'sh8000;
              sum_d   = '0;
              drop_d  = 1'b0;
              state_d = ST_IDLE;
            end else begin
              k_d     = k_q + CNT_W'(1);
              state_d = ST_RD;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // mode write drops any partly gathered vector
    if (cfg_we_i) begin
      kind_d = cfg_wdata_i;
      cnt_d  = '0;
      max_d  = 16'sh8000;
      sum_d  = '0;
      drop_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= MODE_SOFTMAX;
      cnt_q       <= '0;
      max_q       <= 16'sh8000;
      sum_q       <= '0;
      drop_q      <= 1'b0;
      k_q         <= '0;
      pass_q      <= 1'b0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      cnt_q       <= cnt_d;
      max_q       <= max_d;
      sum_q       <= sum_d;
      drop_q      <= drop_d;
      k_q         <= k_d;
      pass_q      <= pass_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q      <= dist_d;
    prod_q      <= prod_d;
    p_q         <= p_d;
    e_q         <= e_d;
    rem_q       <= rem_d;
    num_q       <= num_d;
    div_q       <= div_d;
    neg_q       <= neg_d;
    last_q      <= last_d;
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
    out_ovf_q   <= out_ovf_d;
  end

  `STA_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(VEC_LEN), "element count beyond VEC_LEN")
  `STA_ASSERT(a_walk_in_range, (state_q != ST_IDLE && kind_q == MODE_SOFTMAX) |-> (k_q < cnt_q), "vector walk index past stored count")
  `STA_ASSERT(a_rem_below_div, (state_q == ST_DIV) |-> (rem_q < div_q), "divider remainder not below divisor")
  `STA_ASSERT(a_vector_closes, (emit_go && kind_q == MODE_SOFTMAX && emit_last) |=> (state_q == ST_IDLE && cnt_q == '0), "vector state not cleared after final word")
  `STA_ASSERT_RST(a_reset_quiet, !rst_ni |=> !out_valid_q, "result word valid during reset")

endmodule

// File: verif/softmax_tanh_activation_core_tb.sv
`timescale 1ns / 1ps

module softmax_tanh_activation_core_tb;

  localparam int VEC_LEN        = 64;
  localparam int SETTLE_CYCLES  = 64;
  localparam int STALL_LEN      = 300;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int MAX_REPORTS    = 30;

  typedef enum logic {
    MODE_SOFTMAX = 1'b0,
    MODE_TANH    = 1'b1
  } act_mode_e;

  typedef struct {
    sta_pkg::elem_t value;
    logic           last;
  } in_word_t;

  typedef struct {
    sta_pkg::elem_t value;
    logic           last;
    logic           ovf;
  } res_word_t;

  logic           clk_i     = 1'b0;
  logic           rst_ni    = 1'b0;
  logic           cfg_we    = 1'b0;
  logic           cfg_wdata = 1'b0;
  logic           in_valid  = 1'b0;
  sta_pkg::elem_t in_value  = '0;
  logic           in_last   = 1'b0;
  logic           out_ready = 1'b0;
  logic           in_taken  = 1'b0;

  // pacing controls owned by the stimulus process
  logic no_idle  = 1'b0;
  logic hold_req = 1'b0;

  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   stall_cycles = 0;

  in_word_t  elem_feed_q[$];
  res_word_t result_expect_q[$];

  // predictor state
  act_mode_e      cur_mode = MODE_SOFTMAX;
  sta_pkg::elem_t vec_elems [VEC_LEN];
  int             vec_fill    = 0;
  int             vec_peak    = -32768;
  logic           vec_spilled = 1'b0;

  int fail_count      = 0;
  int words_sent      = 0;
  int results_seen    = 0;
  int softmax_vectors = 0;
  int spilled_vectors = 0;
  int tanh_words      = 0;
  int mode_writes     = 0;

  logic [16:0] exp_whole_q16 [12] = '{
    65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1
  };
  logic [16:0] exp_frac_hi_q16 [16] = '{
    65536, 61565, 57835, 54331, 51039, 47947, 45042, 42313,
    39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664
  };
  logic [16:0] exp_frac_lo_q16 [16] = '{
    65536, 65280, 65026, 64772, 64520, 64268, 64018, 63768,
    63520, 63272, 63025, 62780, 62535, 62291, 62048, 61806
  };

  sta_in_if  elem_if ();
  sta_out_if res_if ();

  assign elem_if.valid         = in_valid;
  assign elem_if.element_value = in_value;
  assign elem_if.element_last  = in_last;
  assign res_if.ready          = out_ready;

  wire in_fire  = in_valid && elem_if.ready;
  wire out_fire = res_if.valid && out_ready;

  softmax_tanh_activation_core #(
    .VEC_LEN(VEC_LEN)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .elem_i     (elem_if),
    .res_o      (res_if)
  );

  initial forever #6 clk_i = ~clk_i;

  // exp(-span/256) in Q16
  function automatic logic [16:0] exp_neg_q16(input int unsigned span);
    int unsigned d;
    logic [63:0] p;
    d = (span > 65535) ? 65535 : span;
    if ((d >> 8) >= 12) return 17'd0;
    p = (64'(exp_whole_q16[d >> 8]) * 64'(exp_frac_hi_q16[(d >> 4) & 15]) + 64'd32768) >> 16;
    p = (p * 64'(exp_frac_lo_q16[d & 15]) + 64'd32768) >> 16;
    return p[16:0];
  endfunction

  function automatic sta_pkg::elem_t tanh_q15(input sta_pkg::elem_t x);
    int xi;
    int mag;
    logic [63:0] e;
    logic [63:0] t;
    sta_pkg::elem_t tq;
    xi  = x;
    mag = (xi < 0) ? -xi : xi;
    e   = 64'(exp_neg_q16(mag * 2));
    t   = ((64'd65536 - e) * 64'd32768 + (64'd65536 + e) / 2) / (64'd65536 + e);
    if (t > 64'd32767) t = 64'd32767;
    tq = t[15:0];
    return (xi < 0) ? -tq : tq;
  endfunction

  function automatic void clear_vector();
    vec_fill    = 0;
    vec_peak    = -32768;
    vec_spilled = 1'b0;
  endfunction

  function automatic void predict_activation(input in_word_t w);
    int unsigned sum;
    logic [63:0] e;
    logic [63:0] q;
    res_word_t r;
    words_sent++;
    if (cur_mode == MODE_TANH) begin
      r.value = tanh_q15(w.value);
      r.last  = w.last;
      r.ovf   = 1'b0;
      result_expect_q.push_back(r);
      tanh_words++;
      return;
    end
    if (vec_fill < VEC_LEN) begin
      vec_elems[vec_fill] = w.value;
      vec_fill++;
      if (w.value > vec_peak) vec_peak = w.value;
    end else begin
      vec_spilled = 1'b1;
    end
    if (!w.last) return;
    sum = 0;
    for (int k = 0; k < vec_fill; k++) sum += exp_neg_q16(vec_peak - vec_elems[k]);
    sum &= 32'h00FF_FFFF;
    for (int k = 0; k < vec_fill; k++) begin
      e = 64'(exp_neg_q16(vec_peak - vec_elems[k]));
      q = (sum != 0) ? (e * 64'd32768 + 64'(sum / 2)) / 64'(sum) : 64'd0;
      if (q > 64'd32767) q = 64'd32767;
      r.value = q[15:0];
      r.last  = (k == vec_fill - 1);
      r.ovf   = vec_spilled;
      result_expect_q.push_back(r);
    end
    softmax_vectors++;
    if (vec_spilled) spilled_vectors++;
    clear_vector();
  endfunction

  function automatic void report_mismatch(input string field, input int got, input int want);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $time);
  endfunction

  function automatic void check_result(input res_word_t got);
    res_word_t want;
    results_seen++;
    if (result_expect_q.size() == 0) begin
      report_mismatch("unexpected result", got.value, 0);
      return;
    end
    want = result_expect_q.pop_front();
    if (got.value !== want.value) report_mismatch("result_value", got.value, want.value);
    if (got.last !== want.last) report_mismatch("result_last", got.last, want.last);
    if (got.ovf !== want.ovf) report_mismatch("overflow_flag", got.ovf, want.ovf);
  endfunction

  // sample both channels at the rising edge
  always @(posedge clk_i) begin
    res_word_t got;
    in_word_t  w;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_fire;
      if (in_fire) begin
        w.value = in_value;
        w.last  = in_last;
        predict_activation(w);
      end
      if (out_fire) begin
        got.value = res_if.result_value;
        got.last  = res_if.result_last;
        got.ovf   = res_if.overflow_flag;
        check_result(got);
      end
    end
  end

  // driver: hold the word until taken, then advance or idle
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_taken)) begin
      if (elem_feed_q.size() != 0 && (no_idle || $urandom_range(99) >= 8)) begin
        in_valid <= 1'b1;
        in_value <= elem_feed_q[0].value;
        in_last  <= elem_feed_q[0].last;
        void'(elem_feed_q.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left <= STALL_LEN;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || ($urandom_range(99) >= 8);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || in_fire || out_fire) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic queue_word(input sta_pkg::elem_t v, input logic l);
    in_word_t w;
    w.value = v;
    w.last  = l;
    elem_feed_q.push_back(w);
  endtask

  function automatic sta_pkg::elem_t pick_element(input sta_pkg::elem_t base);
    sta_pkg::elem_t v;
    case ($urandom_range(3))
      0: v = 16'($urandom);
      1: v = base + 16'($urandom_range(0, 16'h0C00));
      2: v = 16'($urandom_range(0, 16'h0800)) - 16'sh0400;
      default: begin
        case ($urandom_range(3))
          0:       v = 16'sh8000;
          1:       v = 16'sh7FFF;
          2:       v = 16'sh0000;
          default: v = 16'shFFFF;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic queue_vector(input int len);
    sta_pkg::elem_t base;
    base = 16'($urandom);
    for (int i = 0; i < len; i++) queue_word(pick_element(base), i == len - 1);
  endtask

  task automatic write_mode(input act_mode_e m);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    cur_mode = m;
    clear_vector();
    mode_writes++;
  endtask

  // wait until every word is taken and every result is back
  task automatic drain();
    while (elem_feed_q.size() != 0 || in_valid || result_expect_q.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    int count;
    int len;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // softmax after reset: single element saturates, extremes, table edges, ties
    queue_word(16'sh8000, 1'b1);
    queue_word(16'sh7FFF, 1'b0);
    queue_word(16'sh8000, 1'b1);
    queue_word(16'sh0C00, 1'b0);
    queue_word(16'sh0000, 1'b0);
    queue_word(16'sh0100, 1'b0);
    queue_word(16'sh0BFF, 1'b0);
    queue_word(16'shFFFF, 1'b1);
    for (int i = 0; i < 4; i++) queue_word(16'sh0005, i == 3);
    drain();

    // mode write drops a partly gathered vector
    queue_word(16'sh0064, 1'b0);
    queue_word(16'sh00C8, 1'b0);
    drain();
    write_mode(MODE_SOFTMAX);
    queue_word(16'sh012C, 1'b1);
    drain();

    write_mode(MODE_TANH);
    queue_word(16'sh8000, 1'b0);
    queue_word(16'sh7FFF, 1'b1);
    queue_word(16'sh0000, 1'b0);
    queue_word(16'sh0001, 1'b0);
    queue_word(16'shFFFF, 1'b1);
    queue_word(16'sh0600, 1'b0);
    queue_word(16'shFA00, 1'b1);
    queue_word(16'sh0080, 1'b0);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_mode((p % 2) ? MODE_TANH : MODE_SOFTMAX);
      if (p == 1) hold_req = 1'b1;
      no_idle = (p == 2);
      if (p % 2) begin
        for (int i = 0; i < 35; i++) queue_word(pick_element(16'sh0000), 1'($urandom));
      end else begin
        if (p == 2) queue_vector(VEC_LEN + 2);
        if (p == 4) queue_vector(VEC_LEN);
        count = 0;
        while (count < 30) begin
          len = $urandom_range(1, 10);
          queue_vector(len);
          count += len;
        end
      end
      drain();
    end
    no_idle = 1'b0;

    $display("run covered %0d words in, %0d results checked, %0d mode writes",
             words_sent, results_seen, mode_writes);
    $display("softmax vectors %0d (%0d over capacity), tanh words %0d",
             softmax_vectors, spilled_vectors, tanh_words);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
